// ===== design/rsgs_pkg.sv =====
// Shared constants and record layout for the grouped temperature statistics store.
`timescale 1ns / 1ps

package rsgs_pkg;

    // Field widths of one stored record
    localparam int YEAR_W  = 16;
    localparam int MONTH_W = 8;
    localparam int TEMP_W  = 8;
    localparam int CNT_OUT_W = 11;

    // Average format: signed Q8, 16 bits; one quotient bit per divider step
    localparam int FRAC_BITS = 8;
    localparam int Q_BITS    = 16;

    // Request operation codes
    localparam logic OP_APPEND = 1'b0;
    localparam logic OP_QUERY  = 1'b1;

    // Reading limits
    localparam logic signed [TEMP_W-1:0] TEMP_LOW  = -8'sd128;
    localparam logic signed [TEMP_W-1:0] TEMP_HIGH = 8'sd127;

    // One record as held in the log memory
    typedef struct packed {
        logic [YEAR_W-1:0]  year;
        logic [MONTH_W-1:0] month;
        logic [TEMP_W-1:0]  reading;
    } rec_t;

    localparam int REC_W = YEAR_W + MONTH_W + TEMP_W;

endpackage

// ===== design/record_store_group_stats_unit.sv =====
// Top level: bounded temperature log with grouped count, minimum, maximum and Q8 average.
//
//  Channel   Handshake            Fields
//  --------  -------------------  ------------------------------------------------------
//  request   start & !busy        op, year, month, whole_year, temperature
//  result    done (one cycle)     accepted, match_count, min_reading, max_reading, avg_q8
//
// An append is written at the edge that accepts it and its result shows the next
// cycle; busy stays low, so appends may follow every cycle.
// A query over N stored records makes one log read per record, then drains the read;
// when nothing matched its result strobes after the drain, and when something did,
// after the divider (load and 16 quotient steps). busy falls in the strobe cycle, so
// the next request may be taken there.
// Reset empties the log at once; no clearing pass is made, only written entries are read.
// Results cannot be held off by the receiver and are shown for one cycle each.
`timescale 1ns / 1ps

module record_store_group_stats_unit #(
    parameter int RECORD_CAPACITY = 1024
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  start,
    output logic                                  busy,
    input  logic                                  op,
    input  logic [rsgs_pkg::YEAR_W-1:0]           year,
    input  logic [rsgs_pkg::MONTH_W-1:0]          month,
    input  logic                                  whole_year,
    input  logic signed [rsgs_pkg::TEMP_W-1:0]    temperature,
    output logic                                  done,
    output logic                                  accepted,
    output logic [rsgs_pkg::CNT_OUT_W-1:0]        match_count,
    output logic signed [rsgs_pkg::TEMP_W-1:0]    min_reading,
    output logic signed [rsgs_pkg::TEMP_W-1:0]    max_reading,
    output logic signed [rsgs_pkg::Q_BITS-1:0]    avg_q8
);

    import rsgs_pkg::*;

    localparam int CNT_W  = $clog2(RECORD_CAPACITY + 1);
    localparam int ADDR_W = (RECORD_CAPACITY > 1) ? $clog2(RECORD_CAPACITY) : 1;
    localparam int SUM_W  = CNT_W + TEMP_W;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_SCAN = 2'd1;
    localparam logic [1:0] ST_DIV  = 2'd2;

    logic [1:0]                state_reg, state_next;
    logic [CNT_W-1:0]          count_reg;
    logic [CNT_W-1:0]          idx_reg;
    logic                      pend_reg;

    logic [YEAR_W-1:0]         q_year_reg;
    logic [MONTH_W-1:0]        q_month_reg;
    logic                      q_whole_reg;

    logic [CNT_W-1:0]          hits_reg;
    logic signed [TEMP_W-1:0]  mn_reg;
    logic signed [TEMP_W-1:0]  mx_reg;
    logic signed [SUM_W-1:0]   sum_reg;

    logic                      done_reg;
    logic                      accepted_reg;
    logic [CNT_OUT_W-1:0]      match_count_reg;
    logic signed [TEMP_W-1:0]  min_reading_reg;
    logic signed [TEMP_W-1:0]  max_reading_reg;
    logic signed [Q_BITS-1:0]  avg_q8_reg;

    logic                      take;
    logic                      full;
    logic                      wr_en;
    logic                      issue;
    logic                      scan_end;
    logic                      div_start;
    logic                      div_done;
    logic signed [Q_BITS-1:0]  div_q;
    rec_t                      wr_rec;
    rec_t                      rd_rec;
    logic [REC_W-1:0]          rd_word;
    logic                      hit;
    logic signed [TEMP_W-1:0]  rd_temp;
    logic signed [TEMP_W-1:0]  none_min;

    assign take  = start && !busy;
    assign full  = count_reg >= CNT_W'(RECORD_CAPACITY);
    assign wr_en = take && (op == OP_APPEND) && !full;

    assign wr_rec.year    = year;
    assign wr_rec.month   = month;
    assign wr_rec.reading = temperature;

    // Read one record a cycle while the scan index is below the fill count
    assign issue    = (state_reg == ST_SCAN) && (idx_reg < count_reg);
    assign scan_end = (state_reg == ST_SCAN) && !issue && !pend_reg;
    assign div_start = scan_end && (hits_reg != '0);

    rsgs_ram #(
        .WIDTH  (REC_W),
        .DEPTH  (RECORD_CAPACITY),
        .ADDR_W (ADDR_W)
    ) u_log (
        .clk   (clk),
        .we    (wr_en),
        .waddr (count_reg[ADDR_W-1:0]),
        .wdata (wr_rec),
        .re    (issue),
        .raddr (idx_reg[ADDR_W-1:0]),
        .rdata (rd_word)
    );

    assign rd_rec  = rd_word;
    assign rd_temp = $signed(rd_rec.reading);
    assign hit     = pend_reg && (rd_rec.year == q_year_reg)
                     && (q_whole_reg || (rd_rec.month == q_month_reg));

    rsgs_div #(
        .CNT_W (CNT_W)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .sum      (sum_reg),
        .divisor  (hits_reg),
        .done     (div_done),
        .quotient (div_q)
    );

    // Sequencer
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (take && (op == OP_QUERY))
                begin
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if (scan_end)
                begin
                    state_next = (hits_reg != '0) ? ST_DIV : ST_IDLE;
                end
            end
            ST_DIV:
            begin
                if (div_done)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign busy = (state_reg != ST_IDLE);

    // Control state: fill count, scan index, read pipeline flag, result strobe
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            count_reg <= '0;
            idx_reg   <= '0;
            pend_reg  <= 1'b0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            pend_reg  <= issue;
            done_reg  <= (take && (op == OP_APPEND)) || (scan_end && (hits_reg == '0))
                         || ((state_reg == ST_DIV) && div_done);
            if (wr_en)
            begin
                count_reg <= count_reg + 1'b1;
            end
            if (take)
            begin
                idx_reg <= '0;
            end
            else if (issue)
            begin
                idx_reg <= idx_reg + 1'b1;
            end
        end
    end

    // Minimum reported when nothing matched depends on the query kind
    assign none_min = q_whole_reg ? '0 : TEMP_LOW;

    // Query latch, accumulators and result register
    always_ff @(posedge clk)
    begin
        if (take)
        begin
            q_year_reg  <= year;
            q_month_reg <= month;
            q_whole_reg <= whole_year;
            hits_reg    <= '0;
            mn_reg      <= TEMP_HIGH;
            mx_reg      <= TEMP_LOW;
            sum_reg     <= '0;
        end
        else if (hit)
        begin
            hits_reg <= hits_reg + 1'b1;
            sum_reg  <= sum_reg + SUM_W'(rd_temp);
            if (rd_temp < mn_reg)
            begin
                mn_reg <= rd_temp;
            end
            if (rd_temp > mx_reg)
            begin
                mx_reg <= rd_temp;
            end
        end

        if (take && (op == OP_APPEND))
        begin
            accepted_reg    <= !full;
            match_count_reg <= '0;
            min_reading_reg <= '0;
            max_reading_reg <= '0;
            avg_q8_reg      <= '0;
        end
        else if (scan_end && (hits_reg == '0))
        begin
            accepted_reg    <= 1'b0;
            match_count_reg <= '0;
            min_reading_reg <= none_min;
            max_reading_reg <= TEMP_LOW;
            avg_q8_reg      <= '0;
        end
        else if ((state_reg == ST_DIV) && div_done)
        begin
            accepted_reg    <= 1'b0;
            match_count_reg <= CNT_OUT_W'(hits_reg);
            min_reading_reg <= mn_reg;
            max_reading_reg <= mx_reg;
            avg_q8_reg      <= div_q;
        end
    end

    assign done        = done_reg;
    assign accepted    = accepted_reg;
    assign match_count = match_count_reg;
    assign min_reading = min_reading_reg;
    assign max_reading = max_reading_reg;
    assign avg_q8      = avg_q8_reg;

endmodule

// ===== design/rsgs_ram.sv =====
// Generic simple dual-port RAM with one write port and a registered read port.
`timescale 1ns / 1ps

module rsgs_ram #(
    parameter int WIDTH  = 32,
    parameter int DEPTH  = 1024,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [WIDTH-1:0]  wdata,
    input  logic              re,
    input  logic [ADDR_W-1:0] raddr,
    output logic [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write and registered read
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== design/rsgs_div.sv =====
// Restoring divider: signed sum times 256 over an unsigned count, one quotient bit a cycle.
`timescale 1ns / 1ps

module rsgs_div #(
    parameter int CNT_W = 11
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   start,
    input  logic signed [CNT_W+rsgs_pkg::TEMP_W-1:0] sum,
    input  logic [CNT_W-1:0]                       divisor,
    output logic                                   done,
    output logic signed [rsgs_pkg::Q_BITS-1:0]     quotient
);

    import rsgs_pkg::*;

    localparam int SUM_W  = CNT_W + TEMP_W;
    localparam int STEP_W = $clog2(Q_BITS);

    logic [SUM_W-1:0]  mag;
    logic [CNT_W:0]    trial;
    logic              fits;

    logic              run_reg;
    logic              done_reg;
    logic              neg_reg;
    logic [STEP_W-1:0] step_reg;
    logic [CNT_W-1:0]  div_reg;
    logic [CNT_W-1:0]  rem_reg;
    logic [Q_BITS-1:0] lo_reg;
    logic [Q_BITS-1:0] q_reg;

    // Magnitude of the sum; the dividend is this value shifted up by the fraction bits
    assign mag = sum[SUM_W-1] ? SUM_W'(-sum) : SUM_W'(sum);

    // Shift in the next dividend bit and test against the divisor
    assign trial = {rem_reg, lo_reg[Q_BITS-1]};
    assign fits  = trial >= {1'b0, div_reg};

    // Control: run for one step per quotient bit, pulse done after the last
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                run_reg  <= 1'b1;
                step_reg <= '0;
            end
            else if (run_reg)
            begin
                step_reg <= step_reg + 1'b1;
                if (step_reg == STEP_W'(Q_BITS - 1))
                begin
                    run_reg  <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // Datapath: the top part of the dividend is already below the divisor
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            neg_reg <= sum[SUM_W-1];
            div_reg <= divisor;
            rem_reg <= mag[SUM_W-1:FRAC_BITS];
            lo_reg  <= {mag[FRAC_BITS-1:0], {(Q_BITS-FRAC_BITS){1'b0}}};
            q_reg   <= '0;
        end
        else if (run_reg)
        begin
            rem_reg <= fits ? CNT_W'(trial - {1'b0, div_reg}) : trial[CNT_W-1:0];
            lo_reg  <= {lo_reg[Q_BITS-2:0], 1'b0};
            q_reg   <= {q_reg[Q_BITS-2:0], fits};
        end
    end

    assign done     = done_reg;
    assign quotient = neg_reg ? -$signed(q_reg) : $signed(q_reg);

endmodule

// ===== tb/sv/record_store_group_stats_unit_tb.sv =====
// Testbench for the grouped temperature statistics store: queued requests, predictor, checker.
`timescale 1ns / 1ps

module record_store_group_stats_unit_tb;

    import rsgs_pkg::*;

    localparam int RECORD_CAPACITY = 1024;
    localparam int RANDOM_REQUESTS = 508;
    localparam int PHASE_LEN       = 170;
    localparam int SETTLE_CYCLES   = 64;

    // One request as queued for the driver, with the sender gap of its phase
    typedef struct {
        logic                     op;
        logic [YEAR_W-1:0]        year;
        logic [MONTH_W-1:0]       month;
        logic                     whole_year;
        logic signed [TEMP_W-1:0] temperature;
        int                       gap_pct;
        bit                       drain_first;
    } request_t;

    // One result as expected on the result ports
    typedef struct {
        logic                     accepted;
        logic [CNT_OUT_W-1:0]     match_count;
        logic signed [TEMP_W-1:0] min_reading;
        logic signed [TEMP_W-1:0] max_reading;
        logic signed [Q_BITS-1:0] avg_q8;
    } stats_t;

    logic                     clk = 1'b0;
    logic                     rst_n = 1'b0;
    logic                     start = 1'b0;
    logic                     op = OP_APPEND;
    logic [YEAR_W-1:0]        year = '0;
    logic [MONTH_W-1:0]       month = '0;
    logic                     whole_year = 1'b0;
    logic signed [TEMP_W-1:0] temperature = '0;
    logic                     busy;
    logic                     done;
    logic                     accepted;
    logic [CNT_OUT_W-1:0]     match_count;
    logic signed [TEMP_W-1:0] min_reading;
    logic signed [TEMP_W-1:0] max_reading;
    logic signed [Q_BITS-1:0] avg_q8;

    request_t request_q[$];
    stats_t   expected_stats_q[$];
    request_t cur_req;
    int       requests_queued = 0;
    int       requests_taken = 0;
    int       error_count = 0;
    int       cur_gap = 0;
    bit       drain_next = 1'b0;

    // Predictor copy of the log
    logic [YEAR_W-1:0]        log_year    [RECORD_CAPACITY];
    logic [MONTH_W-1:0]       log_month   [RECORD_CAPACITY];
    logic signed [TEMP_W-1:0] log_reading [RECORD_CAPACITY];
    int                       log_fill = 0;

    logic [YEAR_W-1:0] year_pool [5];

    record_store_group_stats_unit #(
        .RECORD_CAPACITY(RECORD_CAPACITY)
    ) dut (
        .clk(clk),
        .rst_n(rst_n),
        .start(start),
        .busy(busy),
        .op(op),
        .year(year),
        .month(month),
        .whole_year(whole_year),
        .temperature(temperature),
        .done(done),
        .accepted(accepted),
        .match_count(match_count),
        .min_reading(min_reading),
        .max_reading(max_reading),
        .avg_q8(avg_q8)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    task automatic report_mismatch(input string msg);
        $display("ERROR at %0t: %s", $time, msg);
        error_count++;
    endtask

    // Apply one request to the log copy and work out its result
    function automatic stats_t predict_stats(request_t r);
        stats_t s;
        int     hits;
        int     lo;
        int     hi;
        int     t;
        int     i;
        longint total;
        longint q;
        s.accepted    = 1'b0;
        s.match_count = '0;
        s.min_reading = '0;
        s.max_reading = '0;
        s.avg_q8      = '0;
        if (r.op == OP_APPEND)
        begin
            if (log_fill < RECORD_CAPACITY)
            begin
                log_year[log_fill]    = r.year;
                log_month[log_fill]   = r.month;
                log_reading[log_fill] = r.temperature;
                log_fill++;
                s.accepted = 1'b1;
            end
            return s;
        end
        hits  = 0;
        total = 0;
        lo    = 127;
        hi    = -128;
        for (i = 0; i < log_fill; i++)
        begin
            if (log_year[i] != r.year)
                continue;
            if (!r.whole_year && log_month[i] != r.month)
                continue;
            t = log_reading[i];
            if (t < lo)
                lo = t;
            if (t > hi)
                hi = t;
            total += t;
            hits++;
        end
        if (hits == 0)
        begin
            // empty group: minimum depends on the kind of query
            s.min_reading = r.whole_year ? 8'sd0 : TEMP_LOW;
            s.max_reading = TEMP_LOW;
            s.avg_q8      = '0;
        end
        else
        begin
            q = (total * 256) / hits;
            s.min_reading = lo[TEMP_W-1:0];
            s.max_reading = hi[TEMP_W-1:0];
            s.avg_q8      = q[Q_BITS-1:0];
        end
        s.match_count = hits[CNT_OUT_W-1:0];
        return s;
    endfunction

    function automatic logic signed [TEMP_W-1:0] pick_reading();
        logic signed [TEMP_W-1:0] t;
        case ($urandom_range(9))
            0: t = TEMP_LOW;
            1: t = TEMP_HIGH;
            2: t = -8'sd1;
            3: t = 8'sd0;
            default: t = TEMP_W'($urandom);
        endcase
        return t;
    endfunction

    task automatic add_req(input logic op_i, input logic [YEAR_W-1:0] y,
                           input logic [MONTH_W-1:0] m, input logic w,
                           input logic signed [TEMP_W-1:0] t);
        request_t r;
        r.op          = op_i;
        r.year        = y;
        r.month       = m;
        r.whole_year  = w;
        r.temperature = t;
        r.gap_pct     = cur_gap;
        r.drain_first = drain_next;
        drain_next    = 1'b0;
        request_q.push_back(r);
        requests_queued++;
    endtask

    task automatic build_stimulus();
        int                       n;
        int                       p;
        int                       gap_by_phase [3];
        logic                     is_query;
        logic [YEAR_W-1:0]        y;
        logic [MONTH_W-1:0]       m;
        logic signed [TEMP_W-1:0] t;
        gap_by_phase = '{0, 61, 11};
        year_pool    = '{16'd2023, 16'd2024, 16'h0000, 16'hFFFF, 16'd0};
        year_pool[4] = YEAR_W'($urandom);

        // Directed: empty log, yearly minimum of 127, truncation, field extremes
        cur_gap = 0;
        add_req(OP_QUERY,  16'd2024, 8'd1,   1'b0, 8'sd0);
        add_req(OP_QUERY,  16'd2024, 8'd1,   1'b1, TEMP_HIGH);
        add_req(OP_APPEND, 16'd2024, 8'd1,   1'b0, TEMP_HIGH);
        add_req(OP_APPEND, 16'd2024, 8'd1,   1'b1, TEMP_HIGH);
        add_req(OP_QUERY,  16'd2024, 8'd7,   1'b1, 8'sd0);
        add_req(OP_QUERY,  16'd2024, 8'd1,   1'b0, TEMP_LOW);
        add_req(OP_APPEND, 16'd2024, 8'd2,   1'b0, TEMP_LOW);
        add_req(OP_APPEND, 16'd2024, 8'd2,   1'b0, -8'sd1);
        add_req(OP_APPEND, 16'd2024, 8'd2,   1'b0, 8'sd0);
        add_req(OP_QUERY,  16'd2024, 8'd2,   1'b0, 8'sd0);
        add_req(OP_APPEND, 16'd2024, 8'd3,   1'b0, -8'sd1);
        add_req(OP_APPEND, 16'd2024, 8'd3,   1'b0, 8'sd0);
        add_req(OP_APPEND, 16'd2024, 8'd3,   1'b0, 8'sd0);
        add_req(OP_QUERY,  16'd2024, 8'd3,   1'b0, 8'sd0);
        add_req(OP_APPEND, 16'hFFFF, 8'hFF,  1'b0, TEMP_LOW);
        add_req(OP_APPEND, 16'h0000, 8'h00,  1'b0, TEMP_HIGH);
        add_req(OP_QUERY,  16'hFFFF, 8'hFF,  1'b0, 8'sd0);
        add_req(OP_QUERY,  16'h0000, 8'h00,  1'b1, 8'sd0);
        add_req(OP_QUERY,  16'd2024, 8'hFF,  1'b1, 8'sd0);
        add_req(OP_QUERY,  16'd2024, 8'd99,  1'b0, 8'sd0);
        add_req(OP_QUERY,  16'd1999, 8'd1,   1'b1, 8'sd0);

        // Random: mostly known years and calendar months, some noise
        for (n = 0; n < RANDOM_REQUESTS; n++)
        begin
            if (n % PHASE_LEN == 0)
            begin
                cur_gap    = gap_by_phase[n / PHASE_LEN];
                drain_next = 1'b1;
            end
            is_query = ($urandom_range(99) < 45);
            if ($urandom_range(99) < 12)
                y = YEAR_W'($urandom);
            else
                y = year_pool[$urandom_range(4)];
            if ($urandom_range(99) < 80)
                m = MONTH_W'($urandom_range(12, 1));
            else
                m = MONTH_W'($urandom);
            t = pick_reading();
            add_req(is_query ? OP_QUERY : OP_APPEND, y, m, 1'($urandom_range(1)), t);
        end

        // Query every pool year on the log as it stands, then one more append
        cur_gap    = 11;
        drain_next = 1'b1;
        for (p = 0; p < 5; p++)
        begin
            add_req(OP_QUERY, year_pool[p], MONTH_W'($urandom_range(12, 1)), 1'b0,
                    pick_reading());
            add_req(OP_QUERY, year_pool[p], MONTH_W'($urandom), 1'b1, pick_reading());
        end
        add_req(OP_APPEND, year_pool[0], 8'd1, 1'b0, TEMP_HIGH);
    endtask

    // Driver: hold a request until taken, then advance to the next one
    always @(posedge clk)
    begin : drive_requests
        bit go;
        if (rst_n)
        begin
            if (start && !busy)
            begin
                expected_stats_q.push_back(predict_stats(cur_req));
                requests_taken++;
            end
            if (!start || !busy)
            begin
                go = 1'b0;
                if (request_q.size() != 0)
                begin
                    go = ($urandom_range(99) >= request_q[0].gap_pct);
                    // hold off until every outstanding result has come
                    if (request_q[0].drain_first && expected_stats_q.size() != 0)
                        go = 1'b0;
                end
                if (go)
                begin
                    cur_req     = request_q.pop_front();
                    start       <= 1'b1;
                    op          <= cur_req.op;
                    year        <= cur_req.year;
                    month       <= cur_req.month;
                    whole_year  <= cur_req.whole_year;
                    temperature <= cur_req.temperature;
                end
                else
                    start <= 1'b0;
            end
        end
    end

    // Monitor: compare each result with the oldest expectation
    always @(posedge clk)
    begin : check_results
        stats_t want;
        if (rst_n && done)
        begin
            if (expected_stats_q.size() == 0)
                report_mismatch("result strobe with no request outstanding");
            else
            begin
                want = expected_stats_q.pop_front();
                if (accepted !== want.accepted)
                    report_mismatch($sformatf("accepted got %b, expected %b",
                                              accepted, want.accepted));
                if (match_count !== want.match_count)
                    report_mismatch($sformatf("match_count got %0d, expected %0d",
                                              match_count, want.match_count));
                if (min_reading !== want.min_reading)
                    report_mismatch($sformatf("min_reading got %0d, expected %0d",
                                              min_reading, want.min_reading));
                if (max_reading !== want.max_reading)
                    report_mismatch($sformatf("max_reading got %0d, expected %0d",
                                              max_reading, want.max_reading));
                if (avg_q8 !== want.avg_q8)
                    report_mismatch($sformatf("avg_q8 got %0d, expected %0d",
                                              avg_q8, want.avg_q8));
            end
        end
    end

    // Main sequence: queue the stimulus, release reset, wait for the drain
    initial
    begin
        build_stimulus();
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        do
            @(posedge clk);
        while (requests_taken != requests_queued || expected_stats_q.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (expected_stats_q.size() != 0)
            report_mismatch($sformatf("%0d results never arrived", expected_stats_q.size()));
        if (error_count == 0)
            $display("** record_store_group_stats_unit: PASSED **");
        else
            $display("** record_store_group_stats_unit: FAILED **");
        $finish;
    end

    // Watchdog
    initial
    begin
        #20_000_000;
        $display("** record_store_group_stats_unit: FAILED **");
        $finish;
    end

endmodule

// ===== record_store_group_stats_unit.f =====
design/rsgs_pkg.sv
design/rsgs_ram.sv
design/rsgs_div.sv
design/record_store_group_stats_unit.sv
tb/sv/record_store_group_stats_unit_tb.sv
